// ===== sv/sorted_hash_table_search_unit_assert.svh =====
`ifndef SORTED_HASH_TABLE_SEARCH_UNIT_ASSERT_SVH
`define SORTED_HASH_TABLE_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, checked outside reset
`define SHTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== sv/shts_pkg.sv =====
`timescale 1ns / 1ps

package shts_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int HASH_W          = 32;
    localparam int IDX_W           = 10;
    localparam int CNT_W           = 11;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic wr;
        logic start;
        logic step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic start_miss;
        logic hit;
        logic more;
    } t_dp_sts;

endpackage

// ===== sv/shts_ram.sv =====
`timescale 1ns / 1ps

module shts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/shts_dp.sv =====
`timescale 1ns / 1ps

module shts_dp
    import shts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [HASH_W-1:0] i_hash_value,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_found,
    output logic [IDX_W-1:0]  o_match_index
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > CNT_W) ? CW : CNT_W;

    logic [CNT_W-1:0]  r_count;
    logic [HASH_W-1:0] r_key;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_hp1;
    logic [AW-1:0]     r_mid;
    logic              r_res_found;
    logic [IDX_W-1:0]  r_res_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_match_index;

    logic [XW-1:0]     cnt_ext;
    logic [CW-1:0]     n_used;
    logic [HASH_W-1:0] rdata;
    logic              key_gt;
    logic [CW-1:0]     lo_nxt;
    logic [CW-1:0]     hp1_nxt;
    logic [CW-1:0]     lo_sel;
    logic [CW-1:0]     hp1_sel;
    logic [CW:0]       mid_sum;
    logic [AW-1:0]     mid_calc;
    logic              wr_ok;

    // table size clamped to the depth
    assign cnt_ext = XW'(r_count);
    assign n_used  = (cnt_ext > XW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);

    assign key_gt  = r_key > rdata;
    assign lo_nxt  = key_gt ? (CW'(r_mid) + CW'(1)) : r_lo;
    assign hp1_nxt = key_gt ? r_hp1 : CW'(r_mid);

    // one adder serves the first probe and every later probe
    assign lo_sel   = i_cmd.start ? '0 : lo_nxt;
    assign hp1_sel  = i_cmd.start ? n_used : hp1_nxt;
    assign mid_sum  = {1'b0, lo_sel} + {1'b0, hp1_sel} - (CW+1)'(1);
    assign mid_calc = mid_sum[AW:1];

    assign wr_ok = i_cmd.wr && (32'(i_entry_index) < 32'(TABLE_DEPTH));

    shts_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_hash_value),
        .i_raddr (mid_calc),
        .o_rdata (rdata)
    );

    assign o_sts.start_miss = (i_hash_value == '0) || (n_used == '0);
    assign o_sts.hit        = rdata == r_key;
    assign o_sts.more       = lo_nxt < hp1_nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key       <= i_hash_value;
            r_lo        <= '0;
            r_hp1       <= n_used;
            r_mid       <= mid_calc;
            r_res_found <= 1'b0;
            r_res_idx   <= '0;
        end else if (i_cmd.step) begin
            if (o_sts.hit) begin
                r_res_found <= 1'b1;
                r_res_idx   <= IDX_W'(r_mid);
            end else begin
                r_lo  <= lo_nxt;
                r_hp1 <= hp1_nxt;
                r_mid <= mid_calc;
            end
        end
        if (i_cmd.out_load) begin
            r_found       <= r_res_found;
            r_match_index <= r_res_idx;
        end
    end

    assign o_found       = r_found;
    assign o_match_index = r_match_index;

endmodule

// ===== sv/shts_ctrl.sv =====
`timescale 1ns / 1ps
`include "sorted_hash_table_search_unit_assert.svh"

module shts_ctrl
    import shts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_command,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_HOLD   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;
    logic   accept;

    assign slot_free = !r_out_valid || i_out_ready;
    assign accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = i_sts.start_miss ? S_HOLD : S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.hit || !i_sts.more) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `SHTS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, slot_free)
    `SHTS_ASSERT_NOW(a_busy_no_accept, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready)
    `SHTS_ASSERT_NEXT(a_trivial_miss, i_clk, i_rst_n,
        accept && (i_command == CMD_LOOKUP) && i_sts.start_miss, r_state == S_HOLD)
    `SHTS_ASSERT_NEXT(a_hold_waits, i_clk, i_rst_n,
        (r_state == S_HOLD) && !slot_free, (r_state == S_HOLD) && r_out_valid)

endmodule

// ===== sv/sorted_hash_table_search_unit.sv =====
// load transaction: table written at the accepting edge, no result
// lookup transaction: accept, then P probes (1 to 11 at depth 1024), then the result is registered and made valid
// no new transaction is accepted until the lookup result is loaded; one probe per cycle through the table read port
// zero hash or empty table answers without probing
// reset (i_rst_n low, synchronous): clears entry_count, controller state and result valid
// table contents stay undefined until loaded
`timescale 1ns / 1ps

module sorted_hash_table_search_unit
    import shts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [HASH_W-1:0] i_hash_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_found,
    output logic [IDX_W-1:0]  o_match_index
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    shts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    shts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (i_entry_index),
        .i_hash_value  (i_hash_value),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_found       (o_found),
        .o_match_index (o_match_index)
    );

endmodule
